>>> rtl/ffpa_pkg.sv
// Shared constants, types and status codes for the first-fit pool allocator.
// No dependencies.
`default_nettype none
package ffpa_pkg;
    localparam int MaxBlocks   = 64;
    localparam int IdxW        = $clog2(MaxBlocks);
    localparam int CntW        = $clog2(MaxBlocks + 1);
    localparam int HeaderBytes = 48;
    localparam int MarkBytes   = 4;
    localparam int PoolMax     = 65536;
    localparam int PosW        = 18;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic start;      // latch request, reset scan
        logic rd;         // issue read at scan index
        logic eval;       // evaluate read data
        logic mv_rd;      // read entry for shift
        logic mv_wr;      // write shifted entry
        logic ins;        // write new entry
        logic done;       // finish, load result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_free;
        logic full;
        logic scan_end;   // scan index reached count
        logic hit;        // gap found / offset matched
        logic fits;       // tail fits after scan
        logic mv_end;     // shift finished
    } t_sts;
endpackage
`default_nettype wire

>>> rtl/first_fit_pool_allocator_unit.sv
// First-fit pool allocator: usage notes
// Slave stream s_axis carries one request per item: tuser = mode (0 alloc,
// 1 free), tdata = request_size [15:0], free_offset [31:16].
// Master stream m_axis carries one result per request: tdata = status [1:0],
// payload_offset [17:2], live_blocks [24:18], zero fill to 32 bits.
// Configuration: i_cfg_we writes i_cfg_wdata into pool_bytes (reset 65536);
// write only while no request is in flight.
// Work per item: a scan of the sorted block table, one entry at a time
// through the single-port table memory (a read state and an evaluate state
// per entry), then a shift of each moved entry (read, write and check
// states). The longest work is a free of the first of 64 blocks, or an
// insert ahead of 63. One request is handled at a time; the next can be
// taken in the cycle after the result is accepted.
// Reset clears the live block count and the sequencer; table contents are
// not cleared and are never read before being written.
// While the receiver stalls, the result holds on m_axis and no new request
// is accepted.
// Depends on ffpa_pkg, ffpa_ctrl, ffpa_datapath.
`default_nettype none
module first_fit_pool_allocator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // request_size, free_offset
    input  wire logic        s_axis_tuser,  // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // status, payload_offset, live_blocks
);
    logic [16:0]     r_pool;
    ffpa_pkg::t_cmd  cmd;
    ffpa_pkg::t_sts  sts;
    logic [1:0]      status;
    logic [15:0]     payload;
    logic [6:0]      count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= 17'(ffpa_pkg::PoolMax);
        end else if (i_cfg_we) begin
            r_pool <= i_cfg_wdata;
        end
    end

    ffpa_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (s_axis_tvalid), .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(sts), .o_cmd(cmd)
    );

    ffpa_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_mode(s_axis_tuser), .i_size(s_axis_tdata[15:0]),
        .i_offset(s_axis_tdata[31:16]), .i_pool(r_pool),
        .o_status(status), .o_payload(payload), .o_count(count)
    );

    assign m_axis_tdata = {7'b0, count, payload, status};
endmodule
`default_nettype wire

>>> rtl/ffpa_datapath.sv
// Block table memory, scan cursor and shift logic of the allocator.
// Depends on ffpa_pkg.
`default_nettype none
module ffpa_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ffpa_pkg::t_cmd   i_cmd,
    output ffpa_pkg::t_sts        o_sts,
    input  wire logic             i_mode,
    input  wire logic [15:0]      i_size,
    input  wire logic [15:0]      i_offset,
    input  wire logic [16:0]      i_pool,
    output logic [1:0]            o_status,
    output logic [15:0]           o_payload,
    output logic [6:0]            o_count
);
    logic [31:0] mem [ffpa_pkg::MaxBlocks];
    logic [31:0] r_rd;
    logic [ffpa_pkg::CntW-1:0] r_cnt, n_cnt;
    logic [ffpa_pkg::CntW-1:0] r_idx;
    logic [ffpa_pkg::CntW-1:0] r_mv;
    logic [ffpa_pkg::PosW-1:0] r_cursor;
    logic [ffpa_pkg::PosW-1:0] r_need;
    logic [15:0] r_size, r_off;
    logic        r_free, r_hit;

    logic [ffpa_pkg::PosW-1:0] s_ext, blk_end, limit;
    logic        gap_ok, match, fits, ok;
    logic [ffpa_pkg::IdxW-1:0] rd_addr;

    assign s_ext   = {2'b0, r_rd[31:16]};
    assign blk_end = s_ext + {2'b0, r_rd[15:0]} +
                     ffpa_pkg::PosW'(ffpa_pkg::HeaderBytes + ffpa_pkg::MarkBytes);
    assign gap_ok  = (s_ext >= r_cursor) && (s_ext - r_cursor >= r_need);
    assign match   = (r_rd[31:16] + 16'(ffpa_pkg::HeaderBytes)) == r_off;
    assign limit   = (i_pool > 17'(ffpa_pkg::PoolMax)) ?
                     ffpa_pkg::PosW'(ffpa_pkg::PoolMax) : ffpa_pkg::PosW'(i_pool);
    assign fits    = (r_cursor <= limit) && (limit - r_cursor >= r_need);
    // request succeeds: free matched, or allocate with room in table and pool
    assign ok      = r_free ? r_hit :
                     ((r_cnt < ffpa_pkg::CntW'(ffpa_pkg::MaxBlocks)) && fits);

    // shift reads come from r_mv-1 on insert, r_mv+1 on removal
    always_comb begin
        if (i_cmd.mv_rd) begin
            rd_addr = r_free ? ffpa_pkg::IdxW'(r_mv + 1'b1) : ffpa_pkg::IdxW'(r_mv - 1'b1);
        end else begin
            rd_addr = r_idx[ffpa_pkg::IdxW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd || i_cmd.mv_rd) begin
            r_rd <= mem[rd_addr];
        end
        if (i_cmd.mv_wr) begin
            mem[r_mv[ffpa_pkg::IdxW-1:0]] <= r_rd;
        end else if (i_cmd.ins) begin
            mem[r_idx[ffpa_pkg::IdxW-1:0]] <= {r_cursor[15:0], r_size};
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.done && ok) begin
            n_cnt = r_free ? r_cnt - 1'b1 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_cmd.start) begin
            r_free   <= i_mode;
            r_size   <= i_size;
            r_off    <= i_offset;
            r_need   <= ffpa_pkg::PosW'(i_size) +
                        ffpa_pkg::PosW'(ffpa_pkg::HeaderBytes + ffpa_pkg::MarkBytes);
            r_cursor <= '0;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            // allocate past the last block shifts nothing
            r_mv     <= r_cnt;
        end
        if (i_cmd.eval) begin
            if ((r_free && match) || (!r_free && gap_ok)) begin
                r_hit <= 1'b1;
                r_mv  <= r_free ? r_idx : r_cnt;
            end else begin
                r_idx <= r_idx + 1'b1;
                if (!r_free) r_cursor <= blk_end;
            end
        end
        if (i_cmd.mv_wr) begin
            r_mv <= r_free ? r_mv + 1'b1 : r_mv - 1'b1;
        end
    end

    // result register, loaded on the controller's done command
    logic [1:0]  r_ost;
    logic [15:0] r_opl;
    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            if (r_free) begin
                r_ost <= r_hit ? ffpa_pkg::ST_OK : ffpa_pkg::ST_NOT_FOUND;
                r_opl <= '0;
            end else if (r_cnt >= ffpa_pkg::CntW'(ffpa_pkg::MaxBlocks)) begin
                r_ost <= ffpa_pkg::ST_TABLE_FULL;
                r_opl <= '0;
            end else if (!fits) begin
                r_ost <= ffpa_pkg::ST_NO_SPACE;
                r_opl <= '0;
            end else begin
                r_ost <= ffpa_pkg::ST_OK;
                r_opl <= r_cursor[15:0] + 16'(ffpa_pkg::HeaderBytes);
            end
        end
    end

    assign o_status  = r_ost;
    assign o_payload = r_opl;
    assign o_count   = 7'(r_cnt);

    always_comb begin
        o_sts.is_free  = r_free;
        o_sts.full     = r_cnt >= ffpa_pkg::CntW'(ffpa_pkg::MaxBlocks);
        o_sts.scan_end = r_idx >= r_cnt;
        o_sts.hit      = r_hit;
        o_sts.fits     = fits;
        o_sts.mv_end   = r_free ? (r_mv + 1'b1 >= r_cnt) : (r_mv <= r_idx);
    end
endmodule
`default_nettype wire

>>> rtl/ffpa_ctrl.sv
// Sequencer for the allocator: scan, shift, insert and respond.
// Depends on ffpa_pkg.
`default_nettype none
module ffpa_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire ffpa_pkg::t_sts i_sts,
    output ffpa_pkg::t_cmd      o_cmd
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RD   = 9'b000000010,
        S_EVAL = 9'b000000100,
        S_DEC  = 9'b000001000,
        S_MVRD = 9'b000010000,
        S_MVWR = 9'b000100000,
        S_INS  = 9'b001000000,
        S_DONE = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_wait;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.start = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                if (!i_sts.is_free && i_sts.full) begin
                    n_state = S_DONE;
                end else if (i_sts.hit || i_sts.scan_end) begin
                    n_state = S_DEC;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = S_RD;
            end
            S_DEC: begin
                if (i_sts.is_free ? !i_sts.hit : !i_sts.fits) begin
                    n_state = S_DONE;
                end else if (i_sts.mv_end) begin
                    n_state = i_sts.is_free ? S_DONE : S_INS;
                end else begin
                    n_state = S_MVRD;
                end
            end
            S_MVRD: begin
                o_cmd.mv_rd = 1'b1;
                n_state = S_MVWR;
            end
            S_MVWR: begin
                o_cmd.mv_wr = 1'b1;
                n_state = S_DEC;
            end
            S_INS: begin
                o_cmd.ins = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= (r_state == S_OUT) && !i_out_ready;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait |-> o_out_valid) else $error("result dropped while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("accept during response");
`endif
endmodule
`default_nettype wire
